FILE: hdl/dxtd_pkg.sv
// shared types, constants and expansion tables for the dxt block decoder
package dxtd_pkg;

	// index of the final pixel in a 4x4 block
	localparam logic [3:0] LAST_INDEX = 4'hF;

	// reciprocal constants for truncating division by 3, 5 and 7
	localparam int RECIP3  = 683;
	localparam int SHIFT3  = 11;
	localparam int RECIP5  = 3277;
	localparam int RECIP7  = 2341;
	localparam int SHIFT57 = 14;

	// 5-bit and 6-bit channel widening, value times 255 over 31 or 63
	function automatic logic [31:0][7:0] build_exp5();
		logic [31:0][7:0] t;
		for (int i = 0; i < 32; i++) begin
			t[i] = 8'(i * 255 / 31);
		end
		return t;
	endfunction

	function automatic logic [63:0][7:0] build_exp6();
		logic [63:0][7:0] t;
		for (int i = 0; i < 64; i++) begin
			t[i] = 8'(i * 255 / 63);
		end
		return t;
	endfunction

	localparam logic [31:0][7:0] EXP5 = build_exp5();
	localparam logic [63:0][7:0] EXP6 = build_exp6();

	// one colour channel palette as produced by a lane
	typedef struct packed {
		logic [7:0] e0;
		logic [7:0] e1;
		logic [7:0] p2;
		logic [7:0] p3;
	} lane_out_t;

	// per-block control travelling alongside the lanes
	typedef struct packed {
		logic        dxt5;
		logic        four_color;
		logic [31:0] codes;
		logic [47:0] aidx;
	} blk_ctrl_t;

endpackage

FILE: hdl/dxtd_color_lane.sv
// one colour channel lane: interpolated palette entries from two endpoints
module dxtd_color_lane import dxtd_pkg::*; (
	input  logic       clk,
	input  logic       en,
	input  logic       four_color,
	input  logic [7:0] e0,
	input  logic [7:0] e1,
	output lane_out_t  lane
);

	logic [9:0]  sum2_s2;
	logic [9:0]  sum3_s2;
	logic [7:0]  half_s2;
	logic [7:0]  e0_s2;
	logic [7:0]  e1_s2;
	logic        four_s2;
	logic [20:0] m2;
	logic [20:0] m3;

	// stage 2: weighted sums
	always_ff @(posedge clk) begin
		if (en) begin
			sum2_s2 <= {1'b0, e0, 1'b0} + {2'b00, e1};
			sum3_s2 <= {2'b00, e0} + {1'b0, e1, 1'b0};
			half_s2 <= 8'(({1'b0, e0} + {1'b0, e1}) >> 1);
			e0_s2   <= e0;
			e1_s2   <= e1;
			four_s2 <= four_color;
		end
	end

	// divide by three through the reciprocal
	assign m2 = 21'(sum2_s2) * 21'(RECIP3);
	assign m3 = 21'(sum3_s2) * 21'(RECIP3);

	// stage 3: palette entries
	always_ff @(posedge clk) begin
		if (en) begin
			lane.e0 <= e0_s2;
			lane.e1 <= e1_s2;
			lane.p2 <= four_s2 ? m2[SHIFT3 +: 8] : half_s2;
			lane.p3 <= four_s2 ? m3[SHIFT3 +: 8] : 8'h00;
		end
	end

endmodule

FILE: hdl/dxtd_alpha_lane.sv
// alpha lane: eight-entry alpha palette from two endpoints
module dxtd_alpha_lane import dxtd_pkg::*; (
	input  logic            clk,
	input  logic            en,
	input  logic [7:0]      a0,
	input  logic [7:0]      a1,
	output logic [7:0][7:0] pal
);

	logic [7:0]       a0_s2;
	logic [7:0]       a1_s2;
	logic             gt_s2;
	logic [5:0][10:0] num_s2;
	logic             gt;

	assign gt = a0 > a1;

	// stage 2: weighted sums, eight-level or six-level mix
	always_ff @(posedge clk) begin
		if (en) begin
			a0_s2 <= a0;
			a1_s2 <= a1;
			gt_s2 <= gt;
		end
	end

	for (genvar k = 1; k <= 6; k++) begin : g_mix
		logic [10:0] num7;
		logic [10:0] num5;
		logic [22:0] prod;
		logic [7:0]  level;

		assign num7 = 11'(7 - k) * {3'b000, a0} + 11'(k) * {3'b000, a1};
		if (k <= 4) begin : g_five
			assign num5 = 11'(5 - k) * {3'b000, a0} + 11'(k) * {3'b000, a1};
		end else begin : g_none
			assign num5 = '0;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				num_s2[k-1] <= gt ? num7 : num5;
			end
		end

		// divide by seven or five through the reciprocal
		assign prod = 23'(num_s2[k-1]) * (gt_s2 ? 23'(RECIP7) : 23'(RECIP5));

		// six-level mode ends in fully transparent and fully opaque
		if (k == 5) begin : g_zero
			assign level = gt_s2 ? prod[SHIFT57 +: 8] : 8'h00;
		end else if (k == 6) begin : g_full
			assign level = gt_s2 ? prod[SHIFT57 +: 8] : 8'hFF;
		end else begin : g_mid
			assign level = prod[SHIFT57 +: 8];
		end

		// stage 3: interpolated entry
		always_ff @(posedge clk) begin
			if (en) begin
				pal[k+1] <= level;
			end
		end
	end

	// stage 3: endpoint entries
	always_ff @(posedge clk) begin
		if (en) begin
			pal[0] <= a0_s2;
			pal[1] <= a1_s2;
		end
	end

endmodule

FILE: hdl/dxtd_merge.sv
// merge stage: joins lane palettes and streams out the sixteen pixels
module dxtd_merge import dxtd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  blk_ctrl_t            ctrl,
	input  lane_out_t [2:0]      col,
	input  logic [7:0][7:0]      apal,
	output logic                 take,
	output logic                 pixel_valid,
	output logic [31:0]          pixel_rgba,
	output logic [3:0]           pixel_index,
	output logic                 last_pixel
);

	logic             active_q;
	logic [3:0]       cnt_q;
	logic [31:0]      codes_q;
	logic [47:0]      aidx_q;
	logic             dxt5_q;
	logic [3:0][31:0] cpal_q;
	logic [7:0][7:0]  apal_q;
	logic             out_v_q;
	logic [31:0]      out_px_q;
	logic [3:0]       out_idx_q;
	logic             out_last_q;
	logic [3:0][31:0] cpal_d;
	logic [7:0]       alpha3;
	logic [31:0]      px;

	// free when idle or on the final pixel of the current block
	assign take = in_valid && (!active_q || cnt_q == LAST_INDEX);

	// colour palette words with opaque alpha, transparent black where marked
	assign alpha3    = ctrl.four_color ? 8'hFF : 8'h00;
	assign cpal_d[0] = {8'hFF, col[2].e0, col[1].e0, col[0].e0};
	assign cpal_d[1] = {8'hFF, col[2].e1, col[1].e1, col[0].e1};
	assign cpal_d[2] = {8'hFF, col[2].p2, col[1].p2, col[0].p2};
	assign cpal_d[3] = {alpha3, col[2].p3, col[1].p3, col[0].p3};

	// current pixel from the low index bits
	always_comb begin
		px = cpal_q[codes_q[1:0]];
		if (dxt5_q) begin
			px[31:24] = apal_q[aidx_q[2:0]];
		end
	end

	// sequencing control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			cnt_q    <= '0;
			out_v_q  <= 1'b0;
		end else begin
			out_v_q <= active_q;
			if (take) begin
				active_q <= 1'b1;
				cnt_q    <= '0;
			end else if (active_q) begin
				active_q <= cnt_q != LAST_INDEX;
				cnt_q    <= cnt_q + 4'd1;
			end
		end
	end

	// block store and index shifters
	always_ff @(posedge clk) begin
		if (take) begin
			codes_q <= ctrl.codes;
			aidx_q  <= ctrl.aidx;
			dxt5_q  <= ctrl.dxt5;
			cpal_q  <= cpal_d;
			apal_q  <= apal;
		end else if (active_q) begin
			codes_q <= codes_q >> 2;
			aidx_q  <= aidx_q >> 3;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (active_q) begin
			out_px_q   <= px;
			out_idx_q  <= cnt_q;
			out_last_q <= cnt_q == LAST_INDEX;
		end
	end

	assign pixel_valid = out_v_q;
	assign pixel_rgba  = out_px_q;
	assign pixel_index = out_idx_q;
	assign last_pixel  = out_last_q;

`ifndef ASSERT_OFF
	// a new block is only loaded while idle or once the previous one is on its final pixel
	a_take_free: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> !active_q || cnt_q == LAST_INDEX)
		else $error("block loaded over a block still streaming");

	// pixels of one block follow each other without a gap
	a_pixel_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && !out_last_q |=> out_v_q && out_idx_q == $past(out_idx_q) + 4'd1)
		else $error("pixel sequence broken inside a block");

	// the last flag marks only the final pixel
	a_last_idx: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && out_last_q |-> out_idx_q == LAST_INDEX)
		else $error("last pixel flag on wrong index");
`endif

endmodule

FILE: hdl/dxt_texture_block_decoder_core.sv
// top level of the dxt1 / dxt5 texture block decoder
//
// usage: a block transaction is taken on a clock edge with start high and
// busy low; low_word and high_word carry the sixteen block bytes. cfg_we
// with cfg_wdata sets the format (0 dxt1, 1 dxt5); change it only while
// no block is in flight. each block gives sixteen pixel transactions in
// row-major order, one per cycle, each shown for one cycle with
// pixel_valid high; last_pixel marks index fifteen.
// the block rate is set by the one-pixel-a-cycle output stream of the
// merge stage; a capture stage and two lane stages (sums, then
// reciprocal multiply) fill while the previous block streams, so start
// may be held high continuously.
// the receiver cannot stall; pixels are never held back once streaming.
// reset clears the format to dxt1 and empties all stages; nothing needs
// clearing beyond that.
module dxt_texture_block_decoder_core import dxtd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        start,
	output logic        busy,
	input  logic [63:0] low_word,
	input  logic [63:0] high_word,
	output logic        pixel_valid,
	output logic [31:0] pixel_rgba,
	output logic [3:0]  pixel_index,
	output logic        last_pixel
);

	logic            fmt_q;
	logic            v_s1;
	logic            v_s2;
	logic            v_s3;
	blk_ctrl_t       ctrl_s1;
	blk_ctrl_t       ctrl_s2;
	blk_ctrl_t       ctrl_s3;
	logic [2:0][7:0] e0_s1;
	logic [2:0][7:0] e1_s1;
	logic [7:0]      a0_s1;
	logic [7:0]      a1_s1;
	logic            accept;
	logic            adv;
	logic            take;
	logic [63:0]     cword;
	logic [15:0]     c0;
	logic [15:0]     c1;
	lane_out_t [2:0] col_s3;
	logic [7:0][7:0] apal_s3;

	// format register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= 1'b0;
		end else if (cfg_we) begin
			fmt_q <= cfg_wdata;
		end
	end

	// pipeline moves whenever the last stage is empty or handed on
	assign adv    = !v_s3 || take;
	assign busy   = v_s1 && !adv;
	assign accept = start && !busy;

	// colour block selection
	assign cword = fmt_q ? high_word : low_word;
	assign c0    = cword[15:0];
	assign c1    = cword[31:16];

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv || !v_s1) begin
				v_s1 <= accept;
			end
			if (adv) begin
				v_s2 <= v_s1;
				v_s3 <= v_s2;
			end
		end
	end

	// stage 1: capture and widen the endpoints
	always_ff @(posedge clk) begin
		if (accept) begin
			e0_s1[0]           <= EXP5[c0[15:11]];
			e0_s1[1]           <= EXP6[c0[10:5]];
			e0_s1[2]           <= EXP5[c0[4:0]];
			e1_s1[0]           <= EXP5[c1[15:11]];
			e1_s1[1]           <= EXP6[c1[10:5]];
			e1_s1[2]           <= EXP5[c1[4:0]];
			a0_s1              <= low_word[7:0];
			a1_s1              <= low_word[15:8];
			ctrl_s1.dxt5       <= fmt_q;
			ctrl_s1.four_color <= fmt_q || (c0 > c1);
			ctrl_s1.codes      <= cword[63:32];
			ctrl_s1.aidx       <= low_word[63:16];
		end
	end

	// block control alongside the lanes
	always_ff @(posedge clk) begin
		if (adv) begin
			ctrl_s2 <= ctrl_s1;
			ctrl_s3 <= ctrl_s2;
		end
	end

	// red, green and blue lanes
	for (genvar g = 0; g < 3; g++) begin : g_lane
		dxtd_color_lane u_color_lane (
			.clk        (clk),
			.en         (adv),
			.four_color (ctrl_s1.four_color),
			.e0         (e0_s1[g]),
			.e1         (e1_s1[g]),
			.lane       (col_s3[g])
		);
	end

	// alpha lane
	dxtd_alpha_lane u_alpha_lane (
		.clk (clk),
		.en  (adv),
		.a0  (a0_s1),
		.a1  (a1_s1),
		.pal (apal_s3)
	);

	// merge and pixel stream
	dxtd_merge u_merge (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (v_s3),
		.ctrl        (ctrl_s3),
		.col         (col_s3),
		.apal        (apal_s3),
		.take        (take),
		.pixel_valid (pixel_valid),
		.pixel_rgba  (pixel_rgba),
		.pixel_index (pixel_index),
		.last_pixel  (last_pixel)
	);

`ifndef ASSERT_OFF
	// an accepted block always lands in the capture stage
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> v_s1)
		else $error("accepted block lost at capture");

	// busy only while a captured block is held back
	a_busy_held: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> v_s1 && v_s3 && !take)
		else $error("busy raised with nothing held");
`endif

endmodule
